>>> design/substring_search_bad_char_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the substring search block
// Immediate-implication and next-cycle-implication checks, clocked and reset
// gated the same way everywhere.
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_SEARCH_BAD_CHAR_ASSERT_SVH
`define SUBSTRING_SEARCH_BAD_CHAR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SSBC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("substring search: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define SSBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("substring search: next-cycle check failed");

`endif

>>> design/ssbc_pkg.sv
// ----------------------------------------------------------------------------
// ssbc_pkg
// Shared constants, types and codes of the substring search block.
// ----------------------------------------------------------------------------
package ssbc_pkg;

    // storage sizes
    localparam int MAX_LEN = 64;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int SUM_W   = LEN_W + 2;
    localparam int CHAR_W  = 8;
    localparam int NCHAR   = 256;
    localparam int POS_W   = 6;

    // search mode codes
    localparam logic MODE_PLAIN = 1'b0;
    localparam logic MODE_SKIP  = 1'b1;

    // input kind codes
    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_TEXT    = 1'b1;

    // search sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_COMP,
        S_SHIFT,
        S_DONE
    } t_state;

    // start request from the load logic
    typedef struct packed {
        logic             start;
        logic             mode;
        logic [LEN_W-1:0] pcount;
        logic [LEN_W-1:0] tcount;
    } t_search_cmd;

    // sequencer status back to the top
    typedef struct packed {
        logic             busy;
        logic             done;
        logic             found;
        logic [LEN_W-1:0] pos;
    } t_search_res;

endpackage

>>> design/ssbc_ram.sv
// ----------------------------------------------------------------------------
// ssbc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ssbc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/ssbc_last_table.sv
// ----------------------------------------------------------------------------
// ssbc_last_table
// Last-occurrence table: rightmost pattern index of each byte value, minus
// one for bytes not seen. Per-entry valid bits clear the table without a clearing pass.
// ----------------------------------------------------------------------------
module ssbc_last_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_clear,
    input  logic                              i_we,
    input  logic [ssbc_pkg::CHAR_W-1:0]       i_waddr,
    input  logic [ssbc_pkg::IDX_W-1:0]        i_wdata,
    input  logic [ssbc_pkg::CHAR_W-1:0]       i_raddr,
    output logic signed [ssbc_pkg::LEN_W:0]   o_last_pos
);

    logic [ssbc_pkg::NCHAR-1:0] r_valid;
    logic                       r_rd_valid;
    logic [ssbc_pkg::IDX_W-1:0] rdata;

    ssbc_ram #(
        .DEPTH (ssbc_pkg::NCHAR),
        .WIDTH (ssbc_pkg::IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_raddr (i_raddr),
        .o_rdata (rdata)
    );

    // valid bits: clear on a new pattern, set on each write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_clear) begin
                r_valid <= '0;
            end
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
        end
    end

    // valid bit read alongside the RAM data
    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_valid[i_raddr];
    end

    // unseen bytes read as minus one
    assign o_last_pos = r_rd_valid ? $signed((ssbc_pkg::LEN_W + 1)'(rdata)) : '1;

endmodule

>>> design/ssbc_seq.sv
// ----------------------------------------------------------------------------
// ssbc_seq
// Search sequencer: walks the shift position and compare index, one byte
// compare per fetch/compare pair, with one shared adder for the advance.
// ----------------------------------------------------------------------------
module ssbc_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ssbc_pkg::t_search_cmd             i_cmd,
    input  logic                              i_out_free,
    input  logic [ssbc_pkg::CHAR_W-1:0]       i_pat_byte,
    input  logic [ssbc_pkg::CHAR_W-1:0]       i_txt_byte,
    input  logic signed [ssbc_pkg::LEN_W:0]   i_last_pos,
    output logic [ssbc_pkg::IDX_W-1:0]        o_pat_addr,
    output logic [ssbc_pkg::IDX_W-1:0]        o_txt_addr,
    output ssbc_pkg::t_search_res             o_res
);

    localparam int LW = ssbc_pkg::LEN_W;
    localparam int IW = ssbc_pkg::IDX_W;
    localparam int SW = ssbc_pkg::SUM_W;

    ssbc_pkg::t_state r_state, n_state;
    logic [LW-1:0]    r_i, n_i;
    logic [IW-1:0]    r_j, n_j;
    logic [LW-1:0]    r_m, n_m;
    logic [LW-1:0]    r_n, n_n;
    logic             r_mode, n_mode;
    logic             r_found, n_found;
    logic [LW-1:0]    r_pos, n_pos;
    logic             done;

    logic [LW:0]            txt_sum;
    logic [LW-1:0]          m_dec;
    logic [LW-1:0]          cmd_m_dec;
    logic [IW-1:0]          m_last;
    logic [IW-1:0]          cmd_m_last;
    logic signed [SW-1:0]   s_step;
    logic [SW-1:0]          advance;
    logic [SW-1:0]          i_next;
    logic                   fits;
    logic                   byte_eq;

    // memory addresses
    assign txt_sum    = {1'b0, r_i} + (LW + 1)'(r_j);
    assign o_pat_addr = r_j;
    assign o_txt_addr = txt_sum[IW-1:0];

    // last compare index of the pattern
    assign m_dec      = r_m - LW'(1);
    assign m_last     = m_dec[IW-1:0];
    assign cmd_m_dec  = i_cmd.pcount - LW'(1);
    assign cmd_m_last = cmd_m_dec[IW-1:0];

    assign byte_eq = (i_pat_byte == i_txt_byte);

    // shared advance unit: step is one, or max(1, j - last occurrence)
    always_comb begin
        s_step = $signed(SW'(r_j)) - SW'(i_last_pos);
        if (r_mode == ssbc_pkg::MODE_SKIP && s_step > $signed(SW'(1))) begin
            advance = SW'(s_step);
        end else begin
            advance = SW'(1);
        end
        i_next = SW'(r_i) + advance;
        fits   = (i_next + SW'(r_m)) <= SW'(r_n);
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssbc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_m     <= n_m;
        r_n     <= n_n;
        r_mode  <= n_mode;
        r_found <= n_found;
        r_pos   <= n_pos;
    end

    // next state and datapath control
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_m     = r_m;
        n_n     = r_n;
        n_mode  = r_mode;
        n_found = r_found;
        n_pos   = r_pos;
        done    = 1'b0;
        case (r_state)
            ssbc_pkg::S_IDLE: begin
                if (i_cmd.start) begin
                    n_m     = i_cmd.pcount;
                    n_n     = i_cmd.tcount;
                    n_mode  = i_cmd.mode;
                    n_i     = '0;
                    n_found = 1'b0;
                    n_pos   = '0;
                    if (i_cmd.pcount == '0 || i_cmd.pcount > i_cmd.tcount) begin
                        n_state = ssbc_pkg::S_DONE;
                    end else begin
                        n_j     = (i_cmd.mode == ssbc_pkg::MODE_SKIP) ? cmd_m_last : '0;
                        n_state = ssbc_pkg::S_FETCH;
                    end
                end
            end
            ssbc_pkg::S_FETCH: begin
                n_state = ssbc_pkg::S_COMP;
            end
            ssbc_pkg::S_COMP: begin
                if (byte_eq) begin
                    if (r_mode == ssbc_pkg::MODE_SKIP) begin
                        if (r_j == '0) begin
                            n_found = 1'b1;
                            n_pos   = r_i;
                            n_state = ssbc_pkg::S_DONE;
                        end else begin
                            n_j     = r_j - IW'(1);
                            n_state = ssbc_pkg::S_FETCH;
                        end
                    end else if (r_j == m_last) begin
                        n_found = 1'b1;
                        n_pos   = r_i;
                        n_state = ssbc_pkg::S_DONE;
                    end else begin
                        n_j     = r_j + IW'(1);
                        n_state = ssbc_pkg::S_FETCH;
                    end
                end else if (r_mode == ssbc_pkg::MODE_SKIP) begin
                    // table data for the mismatching text byte arrives next cycle
                    n_state = ssbc_pkg::S_SHIFT;
                end else if (fits) begin
                    n_i     = i_next[LW-1:0];
                    n_j     = '0;
                    n_state = ssbc_pkg::S_FETCH;
                end else begin
                    n_state = ssbc_pkg::S_DONE;
                end
            end
            ssbc_pkg::S_SHIFT: begin
                if (fits) begin
                    n_i     = i_next[LW-1:0];
                    n_j     = m_last;
                    n_state = ssbc_pkg::S_FETCH;
                end else begin
                    n_state = ssbc_pkg::S_DONE;
                end
            end
            ssbc_pkg::S_DONE: begin
                if (i_out_free) begin
                    done    = 1'b1;
                    n_state = ssbc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ssbc_pkg::S_IDLE;
            end
        endcase
    end

    // status
    assign o_res.busy  = (r_state != ssbc_pkg::S_IDLE);
    assign o_res.done  = done;
    assign o_res.found = r_found;
    assign o_res.pos   = r_pos;

endmodule

>>> design/substring_search_bad_char.sv
// ----------------------------------------------------------------------------
// substring_search_bad_char
// First-occurrence substring search with optional bad character skipping.
// ----------------------------------------------------------------------------
// Pattern and text bytes are taken one per cycle and stored in RAMs of
// MAX_LEN bytes; extra bytes are dropped. A pattern byte that opens a new
// pattern clears the last-occurrence table in that same cycle (valid bits, no
// clearing pass). The text byte flagged last starts a search, and no byte is
// taken until its result has moved into the output register. The search
// sequencer spends a RAM fetch state, then a compare state, on each byte
// compare; in skip mode each mismatch adds a shift state for the table
// lookup. With no pattern or a pattern longer than the text the sequencer
// goes straight to its done state. search_mode is written through
// i_cfg_we / i_cfg_wdata; the user must do so only while the block is idle,
// which the block itself does not enforce.
// ----------------------------------------------------------------------------
module substring_search_bad_char (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_kind,
    input  logic [ssbc_pkg::CHAR_W-1:0]  i_char_code,
    input  logic                         i_last_char,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_found,
    output logic [ssbc_pkg::POS_W-1:0]   o_match_pos
);

`include "substring_search_bad_char_assert.svh"

    localparam int LW = ssbc_pkg::LEN_W;
    localparam int IW = ssbc_pkg::IDX_W;
    localparam int PW = ssbc_pkg::POS_W;

    logic          r_mode;
    logic [LW-1:0] r_pcount, n_pcount;
    logic [LW-1:0] r_tcount, n_tcount;
    logic          r_pat_open;
    logic          r_txt_open;
    logic          r_out_valid;
    logic          r_found;
    logic [PW-1:0] r_pos;

    logic          in_acc;
    logic          pat_acc;
    logic          txt_acc;
    logic [LW-1:0] pat_base;
    logic [LW-1:0] txt_base;
    logic          pat_we;
    logic          txt_we;
    logic          out_free;
    logic [LW+PW-1:0] pos_ext;

    logic [IW-1:0]                 pat_raddr;
    logic [IW-1:0]                 txt_raddr;
    logic [ssbc_pkg::CHAR_W-1:0]   pat_byte;
    logic [ssbc_pkg::CHAR_W-1:0]   txt_byte;
    logic signed [LW:0]            last_pos;
    ssbc_pkg::t_search_cmd         cmd;
    ssbc_pkg::t_search_res         res;

    // input transaction and load addresses
    assign o_in_ready = !res.busy;
    assign in_acc     = i_in_valid && o_in_ready;
    assign pat_acc    = in_acc && (i_kind == ssbc_pkg::KIND_PATTERN);
    assign txt_acc    = in_acc && (i_kind == ssbc_pkg::KIND_TEXT);
    assign pat_base   = r_pat_open ? r_pcount : '0;
    assign txt_base   = r_txt_open ? r_tcount : '0;
    assign pat_we     = pat_acc && (pat_base < LW'(ssbc_pkg::MAX_LEN));
    assign txt_we     = txt_acc && (txt_base < LW'(ssbc_pkg::MAX_LEN));

    // byte counts after this transaction
    always_comb begin
        n_pcount = r_pcount;
        n_tcount = r_tcount;
        if (pat_acc) begin
            n_pcount = pat_we ? pat_base + LW'(1) : pat_base;
        end
        if (txt_acc) begin
            n_tcount = txt_we ? txt_base + LW'(1) : txt_base;
        end
    end

    // load control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= ssbc_pkg::MODE_PLAIN;
            r_pcount   <= '0;
            r_tcount   <= '0;
            r_pat_open <= 1'b0;
            r_txt_open <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            r_pcount <= n_pcount;
            r_tcount <= n_tcount;
            if (pat_acc) begin
                r_pat_open <= !i_last_char;
            end
            if (txt_acc) begin
                r_txt_open <= !i_last_char;
            end
        end
    end

    // search start on the last text byte
    assign cmd.start  = txt_acc && i_last_char;
    assign cmd.mode   = r_mode;
    assign cmd.pcount = r_pcount;
    assign cmd.tcount = n_tcount;

    ssbc_ram #(
        .DEPTH (ssbc_pkg::MAX_LEN),
        .WIDTH (ssbc_pkg::CHAR_W)
    ) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (pat_we),
        .i_waddr (pat_base[IW-1:0]),
        .i_wdata (i_char_code),
        .i_raddr (pat_raddr),
        .o_rdata (pat_byte)
    );

    ssbc_ram #(
        .DEPTH (ssbc_pkg::MAX_LEN),
        .WIDTH (ssbc_pkg::CHAR_W)
    ) u_txt_ram (
        .i_clk   (i_clk),
        .i_we    (txt_we),
        .i_waddr (txt_base[IW-1:0]),
        .i_wdata (i_char_code),
        .i_raddr (txt_raddr),
        .o_rdata (txt_byte)
    );

    ssbc_last_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (pat_acc && !r_pat_open),
        .i_we       (pat_we),
        .i_waddr    (i_char_code),
        .i_wdata    (pat_base[IW-1:0]),
        .i_raddr    (txt_byte),
        .o_last_pos (last_pos)
    );

    ssbc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_out_free (out_free),
        .i_pat_byte (pat_byte),
        .i_txt_byte (txt_byte),
        .i_last_pos (last_pos),
        .o_pat_addr (pat_raddr),
        .o_txt_addr (txt_raddr),
        .o_res      (res)
    );

    // output register
    assign out_free = !r_out_valid || i_out_ready;
    assign pos_ext  = (LW + PW)'(res.pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.done) begin
            r_found <= res.found;
            r_pos   <= pos_ext[PW-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_match_pos = r_pos;

    // checks
    `SSBC_ASSERT_SAME(a_miss_pos_zero, i_clk, i_rst_n, o_out_valid && !o_found, o_match_pos == '0)
    `SSBC_ASSERT_SAME(a_done_slot_free, i_clk, i_rst_n, res.done, !r_out_valid || i_out_ready)
    `SSBC_ASSERT_SAME(a_hit_in_range, i_clk, i_rst_n, res.done && res.found, (ssbc_pkg::SUM_W'(res.pos) + ssbc_pkg::SUM_W'(r_pcount)) <= ssbc_pkg::SUM_W'(r_tcount))
    `SSBC_ASSERT_NEXT(a_last_starts_search, i_clk, i_rst_n, txt_acc && i_last_char, res.busy && !o_in_ready)

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: substring search with bad character skipping
// Loads patterns and texts byte by byte and checks each search result
// against a behavioral predictor. Plain and skip modes are both exercised.
// The run has directed corner cases, random rounds of well-formed pattern and
// text loads with some noise, and a long receiver stall that fills the block.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ssbc_pkg::*;

    localparam int      CLK_HALF       = 6;
    localparam int      RESET_CYCLES   = 9;
    localparam int      SETTLE_CYCLES  = 16;
    localparam longint  TIMEOUT_CYCLES = 20_000_000;

    // expected search outcome
    typedef struct {
        logic             found;
        logic [POS_W-1:0] pos;
    } t_match;

    // DUT ports
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic              i_cfg_wdata = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    logic              i_kind      = KIND_PATTERN;
    logic [CHAR_W-1:0] i_char_code = '0;
    logic              i_last_char = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_found;
    logic [POS_W-1:0]  o_match_pos;

    // predictor state
    logic [CHAR_W-1:0] pat_mem [MAX_LEN];
    logic [CHAR_W-1:0] txt_mem [MAX_LEN];
    int                last_seen [NCHAR];
    int                pat_len  = 0;
    int                txt_len  = 0;
    bit                pat_open = 1'b0;
    bit                txt_open = 1'b0;
    logic              cur_mode = MODE_PLAIN;

    t_match expected_matches [$];
    int     error_count = 0;
    int     items_sent  = 0;
    bit     idle_on     = 1'b0;

    // receiver stall control
    int stall_req  = 0;
    int stall_left = 0;
    int rx_gap     = 0;

    substring_search_bad_char DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_found     (o_found),
        .o_match_pos (o_match_pos)
    );

    // clock
    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // first occurrence of the stored pattern in the stored text
    function automatic void search_text(output logic hit, output logic [POS_W-1:0] pos_out);
        int m;
        int n;
        int i;
        int j;
        int step;
        hit     = 1'b0;
        pos_out = '0;
        m = pat_len;
        n = txt_len;
        i = 0;
        if (m == 0 || m > n) return;
        if (cur_mode == MODE_PLAIN) begin
            for (i = 0; i + m <= n; i++) begin
                j = 0;
                while (j < m && txt_mem[i + j] == pat_mem[j]) j++;
                if (j == m) begin
                    hit     = 1'b1;
                    pos_out = POS_W'(i);
                    return;
                end
            end
        end else begin
            while (i + m <= n) begin
                j = m - 1;
                while (j >= 0 && pat_mem[j] == txt_mem[i + j]) j--;
                if (j < 0) begin
                    hit     = 1'b1;
                    pos_out = POS_W'(i);
                    return;
                end
                // bad character shift, never less than one place
                step = j - last_seen[txt_mem[i + j]];
                if (step < 1) step = 1;
                i += step;
            end
        end
    endfunction

    // update the predictor with one accepted input transaction
    function automatic void predict_item(logic kind, logic [CHAR_W-1:0] code, logic last);
        t_match exp_m;
        if (kind == KIND_PATTERN) begin
            if (!pat_open) begin
                pat_len = 0;
                foreach (last_seen[k]) last_seen[k] = -1;
                pat_open = 1'b1;
            end
            if (pat_len < MAX_LEN) begin
                pat_mem[pat_len] = code;
                last_seen[code]  = pat_len;
                pat_len++;
            end
            if (last) pat_open = 1'b0;
        end else begin
            if (!txt_open) begin
                txt_len  = 0;
                txt_open = 1'b1;
            end
            if (txt_len < MAX_LEN) begin
                txt_mem[txt_len] = code;
                txt_len++;
            end
            if (last) begin
                txt_open = 1'b0;
                search_text(exp_m.found, exp_m.pos);
                expected_matches.push_back(exp_m);
            end
        end
    endfunction

    // narrow alphabet gives many partial matches
    function automatic logic [CHAR_W-1:0] pick_char(bit wide);
        if (wide) return CHAR_W'($urandom_range(0, NCHAR - 1));
        return CHAR_W'($urandom_range(8'h61, 8'h63));
    endfunction

    // send one input transaction, with an optional idle burst first
    task automatic send_item(input logic kind, input logic [CHAR_W-1:0] code,
                             input logic last);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_char_code <= code;
        i_last_char <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_item(kind, code, last);
        items_sent++;
    endtask

    // stop offering and let every expected result come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_matches.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_search_mode(input logic mode_val);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode_val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_mode = mode_val;
    endtask

    // one random round: a pattern followed by a few texts, or noise
    task automatic send_search_round();
        logic [CHAR_W-1:0] pat_bytes [$];
        logic [CHAR_W-1:0] txt_bytes [$];
        int m;
        int n;
        int at;
        int roll;
        int stray;
        bit wide;
        bit keep_open;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            repeat ($urandom_range(1, 6))
                send_item(1'($urandom_range(0, 1)), pick_char(1'b1),
                          $urandom_range(0, 3) == 0);
            return;
        end
        roll = $urandom_range(0, 99);
        if (roll < 85)      m = $urandom_range(1, 6);
        else if (roll < 97) m = $urandom_range(7, 40);
        else                m = $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
        wide      = ($urandom_range(0, 3) == 0);
        keep_open = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < m; k++) pat_bytes.push_back(pick_char(wide));
        for (int k = 0; k < m; k++)
            send_item(KIND_PATTERN, pat_bytes[k], (k == m - 1) && !keep_open);

        repeat ($urandom_range(1, 3)) begin
            roll = $urandom_range(0, 99);
            if (roll < 85)      n = $urandom_range(1, 24);
            else if (roll < 97) n = MAX_LEN;
            else                n = $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
            txt_bytes.delete();
            for (int k = 0; k < n; k++) txt_bytes.push_back(pick_char(wide));
            // plant the pattern most of the time
            if (m <= n && m <= MAX_LEN && $urandom_range(0, 9) < 7) begin
                at = $urandom_range(0, n - m);
                for (int k = 0; k < m; k++) txt_bytes[at + k] = pat_bytes[k];
            end
            stray = ($urandom_range(0, 19) == 0) ? $urandom_range(0, n - 1) : -1;
            for (int k = 0; k < n; k++) begin
                if (k == stray)
                    send_item(KIND_PATTERN, pick_char(wide), 1'($urandom_range(0, 1)));
                send_item(KIND_TEXT, txt_bytes[k], k == n - 1);
            end
        end
    endtask

    // corner cases, run in skip mode
    task automatic test_directed();
        // search before any pattern is loaded
        send_item(KIND_TEXT, 8'hFF, 1'b1);
        // single-byte pattern and text
        send_item(KIND_PATTERN, 8'h00, 1'b1);
        send_item(KIND_TEXT, 8'h00, 1'b1);
        // pattern still open: only the stored bytes are searched
        send_item(KIND_PATTERN, 8'h61, 1'b0);
        send_item(KIND_TEXT, 8'h78, 1'b0);
        send_item(KIND_TEXT, 8'h61, 1'b1);
        // pattern load finished in the middle of a text load
        send_item(KIND_TEXT, 8'h61, 1'b0);
        send_item(KIND_PATTERN, 8'h62, 1'b1);
        send_item(KIND_TEXT, 8'h62, 1'b1);
        // pattern longer than text
        send_item(KIND_PATTERN, 8'h61, 1'b0);
        send_item(KIND_PATTERN, 8'h62, 1'b0);
        send_item(KIND_PATTERN, 8'h63, 1'b1);
        send_item(KIND_TEXT, 8'h61, 1'b0);
        send_item(KIND_TEXT, 8'h62, 1'b1);
        // extreme bytes; the first shift would be negative and is clamped
        send_item(KIND_PATTERN, 8'hFF, 1'b0);
        send_item(KIND_PATTERN, 8'h00, 1'b1);
        send_item(KIND_TEXT, 8'h00, 1'b0);
        send_item(KIND_TEXT, 8'h00, 1'b0);
        send_item(KIND_TEXT, 8'hFF, 1'b0);
        send_item(KIND_TEXT, 8'h00, 1'b1);
        send_item(KIND_TEXT, 8'h00, 1'b0);
        send_item(KIND_TEXT, 8'hFF, 1'b0);
        send_item(KIND_TEXT, 8'h00, 1'b1);
    endtask

    task automatic test_random(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) send_search_round();
    endtask

    // receiver holds off while short searches keep coming
    task automatic test_backpressure();
        logic [CHAR_W-1:0] c;
        stall_req = 300;
        repeat (10) begin
            c = pick_char(1'b1);
            send_item(KIND_PATTERN, c, 1'b1);
            send_item(KIND_TEXT, pick_char(1'b0), 1'b0);
            send_item(KIND_TEXT, c, 1'b1);
        end
        test_random(40);
    endtask

    // receiver ready: long stalls on request, random bursts otherwise
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_req != 0) begin
            stall_left = stall_req;
            stall_req  = 0;
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0) rx_gap = $urandom_range(1, 9);
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_match want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_matches.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual found=%0d pos=%0d",
                         $time, o_found, o_match_pos);
                error_count++;
            end else begin
                want = expected_matches.pop_front();
                if (o_found !== want.found) begin
                    $display("%0t: found mismatch: expected %0d, actual %0d",
                             $time, want.found, o_found);
                    error_count++;
                end
                if (o_match_pos !== want.pos) begin
                    $display("%0t: match_pos mismatch: expected %0d, actual %0d",
                             $time, want.pos, o_match_pos);
                    error_count++;
                end
            end
        end
    end

    // test sequence
    initial begin
        foreach (last_seen[k]) last_seen[k] = -1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_search_mode(MODE_SKIP);
        test_directed();
        idle_on = 1'b1;
        test_random(380);
        set_search_mode(MODE_PLAIN);
        test_random(280);
        test_backpressure();
        // closing stretch without idling
        set_search_mode(MODE_SKIP);
        idle_on = 1'b0;
        test_random(300);

        wait_drained();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
